### sv/mlp_pkg.sv
`timescale 1ns / 1ps
package mlp_pkg;

    localparam int unsigned ACT_W   = 16;
    localparam int unsigned WGT_W   = 20;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned HLC_W   = 2;
    localparam int unsigned OIDX_W  = 4;
    localparam int unsigned OVAL_W  = 13;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INPUT_COUNT  = 2'd0,
        REG_HIDDEN_WIDTH = 2'd1,
        REG_OUTPUT_COUNT = 2'd2,
        REG_HIDDEN_LAYERS = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_INPUT  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAITQ,
        S_RUN,
        S_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_weight;
        logic load_input;
        logic issue;
        logic first;
        logic last;
        logic bias;
        logic out_layer;
        logic out_last;
        logic buf_sel;
    } t_cmd;

    // datapath and queue back to controller
    typedef struct packed {
        logic pipe_busy;
        logic q_empty;
    } t_sts;

    // tag that travels with each product through the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic bias;
        logic out_layer;
        logic out_last;
        logic dst_buf;
    } t_tag;

    typedef struct packed {
        logic [OIDX_W-1:0] idx;
        logic [OVAL_W-1:0] val;
        logic              last;
    } t_res;

endpackage

### sv/mlp_ctrl.sv
`timescale 1ns / 1ps
module mlp_ctrl
    import mlp_pkg::*;
#(
    parameter int MAX_WIDTH         = 16,
    parameter int MAX_WEIGHT_LAYERS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [CFG_W-1:0]     i_input_count,
    input  logic [CFG_W-1:0]     i_hidden_width,
    input  logic [CFG_W-1:0]     i_output_count,
    input  logic [HLC_W-1:0]     i_hidden_layers,
    input  t_sts                 i_sts,
    output t_cmd                 o_cmd,
    output logic [$clog2(MAX_WEIGHT_LAYERS > 1 ? MAX_WEIGHT_LAYERS : 2)-1:0] o_layer,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_row,
    output logic [$clog2(MAX_WIDTH+1)-1:0] o_col,
    output logic [CNT_W-1:0]     o_in_pos
);

    localparam int LW = $clog2(MAX_WEIGHT_LAYERS > 1 ? MAX_WEIGHT_LAYERS : 2);
    localparam int RW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH+1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LW-1:0]    r_layer, n_layer;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic             r_cur, n_cur;
    logic [CW-1:0]    r_src, n_src;
    logic [CW-1:0]    r_dst, n_dst;

    logic [CW-1:0]    w_n_in, w_n_hid, w_n_out;
    logic [LW-1:0]    w_layers;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_accept;

    function automatic logic [CW-1:0] f_clamp(input logic [CFG_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            r = CW'(MAX_WIDTH);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    assign w_n_in  = f_clamp(i_input_count);
    assign w_n_hid = f_clamp(i_hidden_width);
    assign w_n_out = f_clamp(i_output_count);
    assign w_layers = (int'(i_hidden_layers) > MAX_WEIGHT_LAYERS - 1)
                    ? LW'(MAX_WEIGHT_LAYERS - 1) : LW'(i_hidden_layers);
    assign w_cnt_inc = r_count + CNT_W'(1);
    assign w_accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_layer <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_cur   <= 1'b0;
            r_src   <= '0;
            r_dst   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_layer <= n_layer;
            r_row   <= n_row;
            r_col   <= n_col;
            r_cur   <= n_cur;
            r_src   <= n_src;
            r_dst   <= n_dst;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_layer = r_layer;
        n_row   = r_row;
        n_col   = r_col;
        n_cur   = r_cur;
        n_src   = r_src;
        n_dst   = r_dst;
        o_stall = (r_state != S_IDLE);
        o_cmd   = '0;
        o_cmd.buf_sel   = r_cur;
        o_cmd.first     = (r_col == '0);
        o_cmd.last      = (r_col == r_src);
        o_cmd.bias      = (r_col == r_src);
        o_cmd.out_layer = (r_layer == w_layers);
        o_cmd.out_last  = (r_row == RW'(r_dst - CW'(1)));
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_operation == OP_WEIGHT) begin
                    o_cmd.load_weight = 1'b1;
                end
                if (w_accept && i_operation == OP_INPUT) begin
                    o_cmd.load_input = 1'b1;
                    if (int'(w_cnt_inc) < int'(w_n_in)) begin
                        n_count = w_cnt_inc;
                    end else begin
                        n_count = '0;
                        n_layer = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_cur   = 1'b0;
                        n_src   = w_n_in;
                        n_dst   = (w_layers == '0) ? w_n_out : w_n_hid;
                        n_state = S_WAITQ;
                    end
                end
            end
            S_WAITQ: begin
                // hold until the previous results have all left
                if (i_sts.q_empty) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_col == r_src) begin
                    n_col = '0;
                    if (r_row == RW'(r_dst - CW'(1))) begin
                        n_row   = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            S_DRAIN: begin
                // next layer reads what this one writes: let the pipeline empty
                if (!i_sts.pipe_busy) begin
                    if (r_layer == w_layers) begin
                        n_state = S_IDLE;
                    end else begin
                        n_layer = r_layer + LW'(1);
                        n_cur   = ~r_cur;
                        n_src   = r_dst;
                        n_dst   = (r_layer + LW'(1) == w_layers) ? w_n_out : w_n_hid;
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_layer  = r_layer;
    assign o_row    = r_row;
    assign o_col    = r_col;
    assign o_in_pos = r_count;

endmodule

### sv/mlp_dp.sv
`timescale 1ns / 1ps
module mlp_dp
    import mlp_pkg::*;
#(
    parameter int MAX_WIDTH          = 16,
    parameter int MAX_WEIGHT_LAYERS  = 4,
    parameter int SIGMOID_TABLE_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [$clog2(MAX_WEIGHT_LAYERS > 1 ? MAX_WEIGHT_LAYERS : 2)-1:0] i_layer,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_row,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_col,
    input  logic [CNT_W-1:0]         i_in_pos,
    input  logic [1:0]               i_weight_layer,
    input  logic [3:0]               i_weight_row,
    input  logic [4:0]               i_weight_column,
    input  logic signed [WGT_W-1:0]  i_weight_value,
    input  logic signed [ACT_W-1:0]  i_input_value,
    output logic                     o_busy,
    output logic                     o_push,
    output t_res                     o_res
);

    localparam int RW      = $clog2(MAX_WIDTH);
    localparam int ROW_LEN = MAX_WIDTH + 1;
    localparam int WDEPTH  = MAX_WEIGHT_LAYERS * MAX_WIDTH * ROW_LEN;
    localparam int WAW     = $clog2(WDEPTH);
    localparam int ADEPTH  = 2 * MAX_WIDTH;
    localparam int AAW     = $clog2(ADEPTH);
    localparam int PW      = ACT_W + WGT_W;
    localparam int AW      = PW + $clog2(MAX_WIDTH + 2);
    localparam int TB      = SIGMOID_TABLE_BITS;
    localparam int TAB_N   = 1 << TB;

    typedef logic [OVAL_W-1:0] t_tab [TAB_N];

    // shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned f_udiv(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tab f_build();
        t_tab        tab;
        longint      s;
        longint unsigned mag, t, et, term, m, den;
        for (int i = 0; i < TAB_N; i++) begin
            s    = 2 * longint'(i) + 1 - longint'(TAB_N);
            mag  = (s < 0) ? longint'(-s) : longint'(s);
            t    = mag << (30 - TB);
            et   = 64'd1 << 31;
            term = 64'd1 << 31;
            for (int n = 1; n <= 20; n++) begin
                term = f_udiv((term * t) >> 31, 64'(n));
                et   = et + term;
            end
            m = f_udiv(64'd1 << 62, et);
            for (int k = 0; k < 4; k++) begin
                m = (m * m + (64'd1 << 30)) >> 31;
            end
            den = (64'd1 << 31) + m;
            if (s > 0) begin
                tab[i] = OVAL_W'(f_udiv(64'd4096 * (64'd1 << 31) + (den >> 1), den));
            end else begin
                tab[i] = OVAL_W'(f_udiv(64'd4096 * m + (den >> 1), den));
            end
        end
        return tab;
    endfunction

    localparam t_tab SIG_TAB = f_build();

    localparam logic signed [AW-1:0] LIM_HI = AW'((1 << 27) - 1);
    localparam logic signed [AW-1:0] LIM_LO = -AW'(1 << 27);

    logic signed [WGT_W-1:0] r_wmem [WDEPTH];
    logic signed [ACT_W-1:0] r_amem [ADEPTH];

    logic signed [WGT_W-1:0] r_w_rd;
    logic signed [ACT_W-1:0] r_a_rd;
    logic signed [PW-1:0]    r_prod;
    logic signed [AW-1:0]    r_acc;
    logic [TB-1:0]           r_idx;
    logic [OVAL_W-1:0]       r_val;
    t_tag                    r_tag_a, r_tag_b, r_tag_c, r_tag_d, r_tag_e;
    logic [RW-1:0]           r_row_a, r_row_b, r_row_c, r_row_d, r_row_e;

    logic                    w_wr_ok;
    logic [WAW-1:0]          w_wr_addr, w_rd_addr;
    logic [AAW-1:0]          w_a_rd_addr, w_a_wr_addr;
    logic                    w_a_we;
    logic signed [ACT_W-1:0] w_a_wdata;
    logic signed [ACT_W-1:0] w_mult_a;
    logic signed [AW-1:0]    w_sat;
    logic [27:0]             w_sat28;

    assign w_wr_ok = (int'(i_weight_layer) < MAX_WEIGHT_LAYERS)
                  && (int'(i_weight_row) < MAX_WIDTH)
                  && (int'(i_weight_column) <= MAX_WIDTH);
    assign w_wr_addr = WAW'((int'(i_weight_layer) * MAX_WIDTH + int'(i_weight_row)) * ROW_LEN
                          + int'(i_weight_column));
    assign w_rd_addr = WAW'((int'(i_layer) * MAX_WIDTH + int'(i_row)) * ROW_LEN + int'(i_col));

    // the activation read for the bias column is ignored; a column past the buffer reads entry 0
    assign w_a_rd_addr = AAW'(int'(i_cmd.buf_sel) * MAX_WIDTH
                            + (int'(i_col) < MAX_WIDTH ? int'(i_col) : 0));

    always_comb begin
        w_a_we      = 1'b0;
        w_a_wr_addr = AAW'(int'(r_tag_e.dst_buf) * MAX_WIDTH + int'(r_row_e));
        w_a_wdata   = ACT_W'(r_val);
        if (i_cmd.load_input) begin
            w_a_we      = (int'(i_in_pos) < MAX_WIDTH);
            w_a_wr_addr = AAW'(int'(i_in_pos) < MAX_WIDTH ? int'(i_in_pos) : 0);
            w_a_wdata   = i_input_value;
        end else if (r_tag_e.valid) begin
            w_a_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_weight && w_wr_ok) begin
            r_wmem[w_wr_addr] <= i_weight_value;
        end
        r_w_rd <= r_wmem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_amem[w_a_wr_addr] <= w_a_wdata;
        end
        r_a_rd <= r_amem[w_a_rd_addr];
    end

    // bias is weight times 1.0 in Q4.12
    assign w_mult_a = r_tag_a.bias ? ACT_W'(4096) : r_a_rd;

    always_comb begin
        if (r_acc < LIM_LO) begin
            w_sat = LIM_LO;
        end else if (r_acc > LIM_HI) begin
            w_sat = LIM_HI;
        end else begin
            w_sat = r_acc;
        end
        w_sat28 = w_sat[27:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
            r_tag_d <= '0;
            r_tag_e <= '0;
        end else begin
            r_tag_a.valid     <= i_cmd.issue;
            r_tag_a.first     <= i_cmd.first;
            r_tag_a.last      <= i_cmd.last;
            r_tag_a.bias      <= i_cmd.bias;
            r_tag_a.out_layer <= i_cmd.out_layer;
            r_tag_a.out_last  <= i_cmd.out_last;
            r_tag_a.dst_buf   <= ~i_cmd.buf_sel;
            r_tag_b <= r_tag_a;
            // advance only the final product of each sum
            r_tag_c <= {r_tag_b.valid && r_tag_b.last, r_tag_b[$bits(t_tag)-2:0]};
            r_tag_d <= r_tag_c;
            r_tag_e <= r_tag_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_a <= i_row;
        r_row_b <= r_row_a;
        r_prod  <= w_mult_a * r_w_rd;
        if (r_tag_b.valid) begin
            r_acc   <= (r_tag_b.first ? AW'(0) : r_acc) + AW'(r_prod);
            r_row_c <= r_row_b;
        end
        r_row_d <= r_row_c;
        // offset by 8.0: flip the sign bit of the saturated sum
        r_idx   <= {~w_sat28[27], w_sat28[26:28-TB]};
        r_row_e <= r_row_d;
        r_val   <= SIG_TAB[r_idx];
    end

    assign o_busy   = r_tag_a.valid || r_tag_b.valid || r_tag_c.valid
                   || r_tag_d.valid || r_tag_e.valid;
    assign o_push   = r_tag_e.valid && r_tag_e.out_layer;
    assign o_res.idx  = OIDX_W'(r_row_e);
    assign o_res.val  = r_val;
    assign o_res.last = r_tag_e.out_last;

endmodule

### sv/mlp_oq.sv
`timescale 1ns / 1ps
module mlp_oq
    import mlp_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam int PTW = $clog2(DEPTH);
    localparam int QCW = $clog2(DEPTH + 1);

    t_res           r_mem [DEPTH];
    logic [PTW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;
    logic           r_valid;
    t_res           r_out;
    logic           w_pop;

    assign w_pop = (r_cnt != '0) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
        if (w_pop) begin
            r_out <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= (int'(r_wr) == DEPTH - 1) ? '0 : r_wr + PTW'(1);
            end
            if (w_pop) begin
                r_rd <= (int'(r_rd) == DEPTH - 1) ? '0 : r_rd + PTW'(1);
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(w_pop);
            if (w_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_full  = (int'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0) && !r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule

### sv/mlp_sigmoid_inference.sv
`timescale 1ns / 1ps
// channel  | handshake            | payload
// input    | i_valid / o_stall    | i_operation, i_weight_*, i_input_value
// result   | o_valid / i_stall    | o_output_index, o_output_value, o_last
// config   | i_cfg_we             | i_cfg_index, i_cfg_data
// A weight item or a non-final input item is taken while idle and leaves the block
// idle. The final input item of a vector starts an inference: the block first waits
// for the result queue to empty and runs each layer on the single multiply-accumulate
// fed from the weight RAM read port, one product per weight including the bias. Results
// leave a queue at one per cycle while i_stall is low; input items are taken as it drains.
// Synchronous active-low reset clears control state; the weight store is not cleared.
module mlp_sigmoid_inference
    import mlp_pkg::*;
#(
    parameter int MAX_WIDTH          = 16,
    parameter int MAX_WEIGHT_LAYERS  = 4,
    parameter int SIGMOID_TABLE_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_operation,
    input  logic [1:0]              i_weight_layer,
    input  logic [3:0]              i_weight_row,
    input  logic [4:0]              i_weight_column,
    input  logic signed [WGT_W-1:0] i_weight_value,
    input  logic signed [ACT_W-1:0] i_input_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OIDX_W-1:0]       o_output_index,
    output logic [OVAL_W-1:0]       o_output_value,
    output logic                    o_last,
    input  logic                    i_cfg_we,
    input  logic [REG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int LW = $clog2(MAX_WEIGHT_LAYERS > 1 ? MAX_WEIGHT_LAYERS : 2);
    localparam int RW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH+1);

    logic [CFG_W-1:0] r_input_count, r_hidden_width, r_output_count;
    logic [HLC_W-1:0] r_hidden_layers;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [LW-1:0]    w_layer;
    logic [RW-1:0]    w_row;
    logic [CW-1:0]    w_col;
    logic [CNT_W-1:0] w_in_pos;
    logic             w_busy, w_push, w_full, w_empty;
    t_res             w_res, w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count   <= CFG_W'(16);
            r_hidden_width  <= CFG_W'(16);
            r_output_count  <= CFG_W'(16);
            r_hidden_layers <= HLC_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_INPUT_COUNT:   r_input_count   <= i_cfg_data;
                REG_HIDDEN_WIDTH:  r_hidden_width  <= i_cfg_data;
                REG_OUTPUT_COUNT:  r_output_count  <= i_cfg_data;
                REG_HIDDEN_LAYERS: r_hidden_layers <= i_cfg_data[HLC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_sts.pipe_busy = w_busy;
    assign w_sts.q_empty   = w_empty;

    mlp_ctrl #(
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_WEIGHT_LAYERS (MAX_WEIGHT_LAYERS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_input_count  (r_input_count),
        .i_hidden_width (r_hidden_width),
        .i_output_count (r_output_count),
        .i_hidden_layers(r_hidden_layers),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_layer        (w_layer),
        .o_row          (w_row),
        .o_col          (w_col),
        .o_in_pos       (w_in_pos)
    );

    mlp_dp #(
        .MAX_WIDTH          (MAX_WIDTH),
        .MAX_WEIGHT_LAYERS  (MAX_WEIGHT_LAYERS),
        .SIGMOID_TABLE_BITS (SIGMOID_TABLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_layer        (w_layer),
        .i_row          (w_row),
        .i_col          (w_col),
        .i_in_pos       (w_in_pos),
        .i_weight_layer (i_weight_layer),
        .i_weight_row   (i_weight_row),
        .i_weight_column(i_weight_column),
        .i_weight_value (i_weight_value),
        .i_input_value  (i_input_value),
        .o_busy         (w_busy),
        .o_push         (w_push),
        .o_res          (w_res)
    );

    mlp_oq #(
        .DEPTH (MAX_WIDTH)
    ) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_out)
    );

    assign o_output_index = w_out.idx;
    assign o_output_value = w_out.val;
    assign o_last         = w_out.last;

    a_accept_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !w_busy)
        else $error("input item taken while the MAC pipeline is busy");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("result pushed into a full queue");

    a_issue_waits_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.issue && !$past(w_cmd.issue)) |-> $past(w_empty))
        else $error("inference started with results still queued");

endmodule

### tb/mlp_sigmoid_inference_checker.sv
`timescale 1ns / 1ps
module mlp_sigmoid_inference_checker
    import mlp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_stall_in,
    input  logic                    i_operation,
    input  logic [1:0]              i_weight_layer,
    input  logic [3:0]              i_weight_row,
    input  logic [4:0]              i_weight_column,
    input  logic signed [WGT_W-1:0] i_weight_value,
    input  logic signed [ACT_W-1:0] i_input_value,
    input  logic                    i_res_valid,
    input  logic                    i_res_stall,
    input  logic [OIDX_W-1:0]       i_output_index,
    input  logic [OVAL_W-1:0]       i_output_value,
    input  logic                    i_last,
    input  logic                    i_cfg_we,
    input  logic [REG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results_seen,
    output int                      o_inferences
);

    localparam int NW = 16;
    localparam int NL = 4;
    localparam int TBITS = 10;

    logic [OVAL_W-1:0]        sig_lut [1 << TBITS];
    logic signed [WGT_W-1:0]  weights [NL][NW][NW+1];
    int                       acts [2][NW];
    int                       received;
    logic [CFG_W-1:0]         n_in_reg, n_hid_reg, n_out_reg;
    logic [HLC_W-1:0]         layers_reg;
    t_res                     expected_q [$];

    function automatic logic [OVAL_W-1:0] sigmoid_sample(longint s);
        longint unsigned mag, t, et, term, m, den, one;
        one = 64'd1 << 31;
        mag = (s < 0) ? -s : s;
        t = mag << (30 - TBITS);
        et = one;
        term = one;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * t) >> 31) / n;
            et += term;
        end
        m = (64'd1 << 62) / et;
        for (int n = 0; n < 4; n++)
            m = (m * m + (64'd1 << 30)) >> 31;
        den = one + m;
        if (s > 0)
            return OVAL_W'((64'd4096 * one + den / 2) / den);
        return OVAL_W'((64'd4096 * m + den / 2) / den);
    endfunction

    function automatic int clamp_w(logic [CFG_W-1:0] w);
        if (w == 0) return 1;
        if (w > NW) return NW;
        return int'(w);
    endfunction

    function automatic int neuron_out(int layer, int row, int src, int width);
        longint acc, lim;
        lim = 64'sd1 << 27;
        acc = 64'sd4096 * longint'(weights[layer][row][width]);
        for (int c = 0; c < width; c++)
            acc += longint'(acts[src][c]) * longint'(weights[layer][row][c]);
        if (acc < -lim) acc = -lim;
        if (acc > lim - 1) acc = lim - 1;
        return int'(sig_lut[(acc + lim) >> (28 - TBITS)]);
    endfunction

    task automatic predict_inference();
        int n_in, n_hid, n_out, nlayers, cur, src_w, dst_w;
        t_res r;
        n_in = clamp_w(n_in_reg);
        n_hid = clamp_w(n_hid_reg);
        n_out = clamp_w(n_out_reg);
        nlayers = int'(layers_reg);
        cur = 0;
        src_w = n_in;
        for (int l = 0; l <= nlayers; l++) begin
            dst_w = (l == nlayers) ? n_out : n_hid;
            for (int k = 0; k < dst_w; k++)
                acts[cur ^ 1][k] = neuron_out(l, k, cur, src_w);
            cur ^= 1;
            src_w = dst_w;
        end
        for (int k = 0; k < n_out; k++) begin
            r.idx = OIDX_W'(k);
            r.val = OVAL_W'(acts[cur][k]);
            r.last = (k + 1 == n_out);
            expected_q = {expected_q, r};
        end
        o_inferences++;
    endtask

    initial begin
        for (int i = 0; i < (1 << TBITS); i++)
            sig_lut[i] = sigmoid_sample(2 * i + 1 - (1 << TBITS));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            received = 0;
            n_in_reg = 16;
            n_hid_reg = 16;
            n_out_reg = 16;
            layers_reg = 1;
            expected_q.delete();
            o_fail_count = 0;
            o_results_seen = 0;
            o_inferences = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_INPUT_COUNT:   n_in_reg = i_cfg_data;
                    REG_HIDDEN_WIDTH:  n_hid_reg = i_cfg_data;
                    REG_OUTPUT_COUNT:  n_out_reg = i_cfg_data;
                    REG_HIDDEN_LAYERS: layers_reg = i_cfg_data[HLC_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (t_op'(i_operation) == OP_WEIGHT) begin
                    // columns past the bias slot are dropped
                    if (i_weight_column <= NW)
                        weights[i_weight_layer][i_weight_row][i_weight_column] =
                            i_weight_value;
                end else begin
                    if (received < NW)
                        acts[0][received] = int'(i_input_value);
                    received = (received + 1) & 31;
                    if (received >= clamp_w(n_in_reg)) begin
                        received = 0;
                        predict_inference();
                    end
                end
            end
            if (i_res_valid && !i_res_stall) begin
                t_res exp_r;
                o_results_seen++;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: index %0d value %0d last %0b",
                                 i_output_index, i_output_value, i_last);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.idx !== i_output_index || exp_r.val !== i_output_value ||
                        exp_r.last !== i_last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result mismatch: expected idx %0d val %0d last %0b, %s",
                                     exp_r.idx, exp_r.val, exp_r.last,
                                     $sformatf("got idx %0d val %0d last %0b",
                                               i_output_index, i_output_value, i_last));
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### tb/mlp_sigmoid_inference_test.sv
`timescale 1ns / 1ps
module mlp_sigmoid_inference_test;
    import mlp_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_operation;
    logic [1:0]              i_weight_layer;
    logic [3:0]              i_weight_row;
    logic [4:0]              i_weight_column;
    logic signed [WGT_W-1:0] i_weight_value;
    logic signed [ACT_W-1:0] i_input_value;
    logic                    o_valid;
    logic                    i_stall;
    logic [OIDX_W-1:0]       o_output_index;
    logic [OVAL_W-1:0]       o_output_value;
    logic                    o_last;
    logic                    i_cfg_we;
    logic [REG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    int fail_count, pending, results_seen, inferences;
    int idle_pct;
    int items_sent;
    int quiet_cycles;
    int input_count_now;

    mlp_sigmoid_inference u_top (.*);

    mlp_sigmoid_inference_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_operation,
        .i_weight_layer, .i_weight_row, .i_weight_column, .i_weight_value,
        .i_input_value, .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_output_index(o_output_index), .i_output_value(o_output_value),
        .i_last(o_last), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_inferences(inferences)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        i_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);

    // end the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(t_op op, logic [1:0] layer, logic [3:0] row,
                             logic [4:0] col, logic signed [WGT_W-1:0] wval,
                             logic signed [ACT_W-1:0] ival);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_weight_layer <= layer;
        i_weight_row <= row;
        i_weight_column <= col;
        i_weight_value <= wval;
        i_input_value <= ival;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_INPUT_COUNT)
            input_count_now = (data == 0) ? 1 : (data > 16 ? 16 : int'(data));
    endtask

    // hold until the block has nothing left to deliver, then let it settle
    task automatic drain_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [WGT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return -(1 <<< 19);
            1: return (1 << 19) - 1;
            2, 3: return WGT_W'($urandom);
            default: return WGT_W'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    function automatic logic signed [ACT_W-1:0] pick_input();
        case ($urandom_range(9))
            0: return -(1 <<< 15);
            1: return (1 << 15) - 1;
            2, 3, 4: return ACT_W'($urandom);
            default: return ACT_W'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    task automatic send_weight(logic [4:0] col);
        send_item(OP_WEIGHT, 2'($urandom), 4'($urandom), col, pick_weight(), '0);
    endtask

    task automatic send_vector(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0)
                send_weight(5'($urandom_range(16)));
            send_item(OP_INPUT, 2'($urandom), 4'($urandom), 5'($urandom), WGT_W'($urandom),
                      pick_input());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_WEIGHT;
        i_weight_layer = '0;
        i_weight_row = '0;
        i_weight_column = '0;
        i_weight_value = '0;
        i_input_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_INPUT_COUNT;
        i_cfg_data = '0;
        items_sent = 0;
        input_count_now = 16;
        idle_pct = 7;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every weight slot so no inference reads an unwritten one
        idle_pct = 0;
        for (int l = 0; l < 4; l++)
            for (int r = 0; r < 16; r++)
                for (int c = 0; c <= 16; c++)
                    send_item(OP_WEIGHT, 2'(l), 4'(r), 5'(c),
                              WGT_W'($signed($urandom_range(4096)) - 2048), '0);
        items_sent = 0;
        idle_pct = 7;

        // directed: extreme weights, dropped columns, extreme inputs at reset settings
        send_item(OP_WEIGHT, 2'd0, 4'd0, 5'd0, -(1 <<< 19), '0);
        send_item(OP_WEIGHT, 2'd3, 4'd15, 5'd16, (1 << 19) - 1, '0);
        send_item(OP_WEIGHT, 2'd1, 4'd2, 5'd17, (1 << 19) - 1, '0);
        send_item(OP_WEIGHT, 2'd2, 4'd9, 5'd31, -(1 <<< 19), '0);
        for (int k = 0; k < 16; k++)
            send_item(OP_INPUT, '0, '0, '0, '0,
                      (k % 3 == 0) ? -(1 <<< 15) : (k % 3 == 1) ? (1 << 15) - 1 : '0);
        drain_block();

        // directed: zero widths act as one, no hidden layers, then deepest network
        write_reg(REG_INPUT_COUNT, 5'd0);
        write_reg(REG_OUTPUT_COUNT, 5'd0);
        write_reg(REG_HIDDEN_LAYERS, 2'd0);
        send_vector(1);
        drain_block();
        write_reg(REG_INPUT_COUNT, 5'd31);
        write_reg(REG_HIDDEN_WIDTH, 5'd31);
        write_reg(REG_OUTPUT_COUNT, 5'd31);
        write_reg(REG_HIDDEN_LAYERS, 2'd3);
        send_vector(16);
        drain_block();

        // random phases; some end part way through a vector so the next
        // setting meets a non-zero element count
        while (items_sent < 210) begin
            write_reg(REG_INPUT_COUNT, ($urandom_range(3) == 0) ? 5'($urandom) :
                      5'($urandom_range(1, 6)));
            write_reg(REG_HIDDEN_WIDTH, ($urandom_range(3) == 0) ? 5'($urandom) :
                      5'($urandom_range(1, 6)));
            write_reg(REG_OUTPUT_COUNT, 5'($urandom));
            write_reg(REG_HIDDEN_LAYERS, 2'($urandom));
            idle_pct = ($urandom_range(4) == 0) ? 0 : 7;
            for (int v = $urandom_range(1, 3); v > 0; v--)
                send_vector(input_count_now);
            if ($urandom_range(3) == 0)
                send_vector($urandom_range(input_count_now - 1));
            drain_block();
        end
        idle_pct = 7;

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);

        $display("sent %0d items after the weight fill, %0d inferences, %0d results checked",
                 items_sent, inferences, results_seen);
        $display("covered zero to three hidden layers, clamped widths and partial vectors");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
